// ----- hw/rtl/alb_pkg.sv -----
// Shared constants, codes and types of the boundary-tag allocator.
package alb_pkg;

    localparam int unsigned HEAP_BYTES_DEF  = 65536;
    localparam int unsigned CHUNK_BYTES_DEF = 4096;

    localparam int unsigned WSIZE       = 4;
    localparam int unsigned DSIZE       = 8;
    localparam int unsigned MIN_BLOCK   = 16;
    localparam int unsigned FIRST_BLOCK = 8;
    localparam int unsigned PAYLOAD0    = 16;
    localparam int unsigned INIT_WORDS  = 6;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OOM  = 2'd2;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

endpackage

// ----- hw/rtl/alb_if.sv -----
// Request and response channel interfaces of the allocator.
interface alb_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [16:0] req_size;
    logic [15:0] block_addr;

    modport source (output valid, output kind, output req_size, output block_addr,
                    input ready);
    modport sink (input valid, input kind, input req_size, input block_addr,
                  output ready);
endinterface

interface alb_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] result_addr;
    logic [1:0]  status;

    modport source (output valid, output result_addr, output status, input ready);
    modport sink (input valid, input result_addr, input status, output ready);
endinterface

// ----- hw/rtl/alb_alu.sv -----
// Shared add/subtract unit used by the allocator sequencer.
module alb_alu #(
    parameter int unsigned W = 19
) (
    input  alb_pkg::t_alu_op i_op,
    input  logic [W-1:0]     i_a,
    input  logic [W-1:0]     i_b,
    output logic [W-1:0]     o_y
);

    always_comb begin
        case (i_op)
            alb_pkg::ALU_ADD: o_y = i_a + i_b;
            alb_pkg::ALU_SUB: o_y = i_a - i_b;
            default:          o_y = i_a;
        endcase
    end

endmodule

// ----- hw/rtl/alb_tag_ram.sv -----
// Tag word memory: one write port, one read port with registered data.
module alb_tag_ram #(
    parameter int unsigned DEPTH = 16384,
    parameter int unsigned IW    = 14,
    parameter int unsigned DW    = 19
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [IW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [IW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/boundary_tag_first_fit_allocator.sv -----
// Top level: first-fit boundary-tag heap allocator with its sequencer.
//
// Requests come in on i_req (kind, req_size, block_addr) and one response
// per request leaves on o_rsp (result_addr, status). i_req.ready is high
// only while the sequencer is idle; one request is worked on at a time.
// All tags live in one single-port-read memory, one word per 4 bytes.
// Allocate walks the blocks first fit; if none fits it grows the heap and
// coalesces the new chunk, then places the block and splits off any rest of
// 8 bytes or more. Free checks the address and the header tag and then
// coalesces; a rejected address ends early. Zero-size requests go straight to the response.
// The walk is bound by the single tag read port and the shared adder.
// After reset the sequencer writes the initial layout (pad, prologue, one
// free chunk, epilogue) and then raises ready.
// A finished response sits in an output register; a new request may be
// accepted while it waits. If the receiver stalls and that register is
// still full when the next response is done, the sequencer holds.
module boundary_tag_first_fit_allocator #(
    parameter int unsigned HEAP_BYTES  = alb_pkg::HEAP_BYTES_DEF,
    parameter int unsigned CHUNK_BYTES = alb_pkg::CHUNK_BYTES_DEF
) (
    input logic       i_clk,
    input logic       i_rst_n,
    alb_req_if.sink   i_req,
    alb_rsp_if.source o_rsp
);

    localparam int unsigned HB    = $clog2(HEAP_BYTES);
    localparam int unsigned W     = (HB + 2 > 19) ? HB + 2 : 19;
    localparam int unsigned DEPTH = HEAP_BYTES / 4;
    localparam int unsigned IW    = $clog2(DEPTH);

    localparam logic [W-1:0] HEAP_W  = W'(HEAP_BYTES);
    localparam logic [W-1:0] CHUNK_W = W'(CHUNK_BYTES);
    localparam logic [W-1:0] WS      = W'(alb_pkg::WSIZE);
    localparam logic [W-1:0] DS      = W'(alb_pkg::DSIZE);
    localparam logic [W-1:0] PAY0    = W'(alb_pkg::PAYLOAD0);
    localparam logic [W-1:0] HEND0   = W'(alb_pkg::PAYLOAD0 + CHUNK_BYTES);
    localparam logic [W-1:0] ONE     = W'(1);
    localparam logic [2:0]   INIT_LAST = 3'(alb_pkg::INIT_WORDS - 1);

    typedef enum logic [4:0] {
        S_INIT, S_IDLE,
        S_F_CHK, S_F_HDR, S_F_FTR,
        S_M_PRV, S_M_NXT, S_M_DEC, S_M_ADD, S_M_W1, S_M_W2, S_M_W3,
        S_P_RD, S_P_DEC, S_P_W1, S_P_W2, S_P_W3, S_P_W4,
        S_W_CHK, S_W_TAG, S_W_ADV,
        S_G_CALC, S_G_CHK, S_G_W1, S_G_W2, S_G_W3,
        S_DONE
    } t_state;

    t_state        r_state;
    logic [2:0]    r_icnt;
    logic          r_kind;
    logic [W-1:0]  r_bp, r_size, r_psize, r_nsize, r_tot, r_nxt, r_asize, r_heap_end;
    logic          r_pused, r_nused, r_split, r_roob;
    logic [15:0]   r_res, r_oaddr;
    logic [1:0]    r_status, r_ostat;
    logic          r_ovld;

    alb_pkg::t_alu_op alu_op;
    logic [W-1:0]  alu_a, alu_b, alu_y;
    logic          mem_we;
    logic [W-1:0]  mem_waddr, mem_wdata, mem_raddr;
    logic [W-1:0]  ram_rdata, tag_rd, tag_s;
    logic [W-1:0]  init_addr, init_data;
    logic [W-1:0]  req_w, asize_calc, ext, grow_calc;
    logic [W-1:0]  split_sz;
    logic          merge_to_place;

    alb_alu #(.W(W)) u_alu (
        .i_op(alu_op), .i_a(alu_a), .i_b(alu_b), .o_y(alu_y)
    );

    alb_tag_ram #(.DEPTH(DEPTH), .IW(IW), .DW(W)) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we && (mem_waddr < HEAP_W)),
        .i_waddr(mem_waddr[IW+1:2]),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr[IW+1:2]),
        .o_rdata(ram_rdata)
    );

    // tags outside the arena read as zero
    assign tag_rd = r_roob ? '0 : ram_rdata;
    assign tag_s  = {tag_rd[W-1:3], 3'b000};

    assign req_w      = W'(i_req.req_size);
    assign asize_calc = (req_w <= DS) ? W'(alb_pkg::MIN_BLOCK)
                                      : ((req_w + W'(15)) & ~W'(7));
    assign ext        = (r_asize > CHUNK_W) ? r_asize : CHUNK_W;
    assign grow_calc  = {ext[W-1:2] + (W-2)'(ext[2]), 2'b00};
    assign split_sz   = r_split ? r_asize : r_size;
    assign merge_to_place = (r_kind == alb_pkg::KIND_ALLOC);

    always_comb begin
        case (r_icnt)
            3'd0:    begin init_addr = '0;               init_data = '0;          end
            3'd1:    begin init_addr = WS;               init_data = DS | ONE;    end
            3'd2:    begin init_addr = DS;               init_data = DS | ONE;    end
            3'd3:    begin init_addr = PAY0 - WS;        init_data = CHUNK_W;     end
            3'd4:    begin init_addr = HEND0 - DS;       init_data = CHUNK_W;     end
            default: begin init_addr = HEND0 - WS;       init_data = ONE;         end
        endcase
    end

    always_comb begin
        alu_op    = alb_pkg::ALU_ADD;
        alu_a     = r_bp;
        alu_b     = r_size;
        mem_we    = 1'b0;
        mem_waddr = r_bp - WS;
        mem_wdata = r_size;
        mem_raddr = r_bp - WS;
        case (r_state)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = init_addr;
                mem_wdata = init_data;
            end
            S_F_HDR: begin
                alu_op    = alb_pkg::ALU_SUB;
                alu_a     = r_heap_end;
                alu_b     = r_bp;
                mem_we    = !(tag_s == '0 || tag_s > alu_y);
                mem_wdata = tag_s;
            end
            S_F_FTR: begin
                mem_we    = 1'b1;
                mem_waddr = alu_y - DS;
            end
            S_M_PRV: mem_raddr = r_bp - DS;
            S_M_NXT: mem_raddr = alu_y - WS;
            S_M_DEC: begin
                alu_a = r_size;
                alu_b = r_pused ? tag_s : r_psize;
            end
            S_M_ADD: begin
                alu_a = r_tot;
                alu_b = r_nsize;
            end
            S_M_W1: begin
                mem_we    = 1'b1;
                mem_wdata = r_tot;
                if (r_pused) begin
                    mem_waddr = r_bp - WS;
                end else if (r_nused) begin
                    alu_op    = alb_pkg::ALU_SUB;
                    alu_b     = r_psize;
                    mem_waddr = alu_y - WS;
                end else begin
                    alu_a     = r_nxt;
                    alu_b     = r_nsize;
                    mem_waddr = alu_y - DS;
                end
            end
            S_M_W2: begin
                mem_we    = 1'b1;
                mem_wdata = r_tot;
                if (r_pused) begin
                    alu_b     = r_tot;
                    mem_waddr = alu_y - DS;
                end else if (r_nused) begin
                    mem_waddr = alu_y - DS;
                end else begin
                    alu_op    = alb_pkg::ALU_SUB;
                    alu_b     = r_psize;
                    mem_waddr = alu_y - WS;
                end
            end
            S_M_W3: begin
                alu_op = alb_pkg::ALU_SUB;
                alu_b  = r_psize;
            end
            S_P_DEC: begin
                alu_op = alb_pkg::ALU_SUB;
                alu_a  = tag_s;
                alu_b  = r_asize;
            end
            S_P_W1: begin
                mem_we    = 1'b1;
                mem_wdata = split_sz | ONE;
            end
            S_P_W2: begin
                alu_b     = split_sz;
                mem_we    = 1'b1;
                mem_waddr = alu_y - DS;
                mem_wdata = split_sz | ONE;
            end
            S_P_W3: begin
                alu_b     = r_asize;
                mem_we    = 1'b1;
                mem_waddr = alu_y - WS;
                mem_wdata = r_tot;
            end
            S_P_W4: begin
                mem_we    = 1'b1;
                mem_waddr = alu_y - DS;
                mem_wdata = r_tot;
            end
            S_W_TAG: begin
                alu_op = alb_pkg::ALU_SUB;
                alu_a  = r_heap_end;
                alu_b  = r_bp;
            end
            S_G_CHK: begin
                alu_a = r_heap_end;
                alu_b = r_tot;
            end
            S_G_W1: mem_we = 1'b1;
            S_G_W2: begin
                mem_we    = 1'b1;
                mem_waddr = alu_y - DS;
            end
            S_G_W3: begin
                mem_we    = 1'b1;
                mem_waddr = alu_y - WS;
                mem_wdata = ONE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_icnt     <= '0;
            r_heap_end <= HEND0;
            r_ovld     <= 1'b0;
        end else begin
            if (r_ovld && o_rsp.ready && r_state != S_DONE) begin
                r_ovld <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    r_icnt <= r_icnt + 3'd1;
                    if (r_icnt == INIT_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_kind   <= i_req.kind;
                        r_res    <= '0;
                        r_status <= alb_pkg::ST_DONE;
                        r_asize  <= asize_calc;
                        if (i_req.kind == alb_pkg::KIND_FREE) begin
                            r_bp    <= W'(i_req.block_addr);
                            r_state <= S_F_CHK;
                        end else if (i_req.req_size == '0) begin
                            r_status <= alb_pkg::ST_ZERO;
                            r_state  <= S_DONE;
                        end else begin
                            r_bp    <= W'(alb_pkg::FIRST_BLOCK);
                            r_state <= S_W_CHK;
                        end
                    end
                end
                S_F_CHK: begin
                    if (r_bp[2:0] != 3'b000 || r_bp < PAY0 || r_bp >= r_heap_end) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_F_HDR;
                    end
                end
                S_F_HDR: begin
                    r_size <= tag_s;
                    if (tag_s == '0 || tag_s > alu_y) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_F_FTR;
                    end
                end
                S_F_FTR: r_state <= S_M_PRV;
                S_M_PRV: r_state <= S_M_NXT;
                S_M_NXT: begin
                    r_psize <= tag_s;
                    r_pused <= tag_rd[0];
                    r_nxt   <= alu_y;
                    r_state <= S_M_DEC;
                end
                S_M_DEC: begin
                    r_nsize <= tag_s;
                    r_nused <= tag_rd[0];
                    r_tot   <= alu_y;
                    if (r_pused && tag_rd[0]) begin
                        r_state <= merge_to_place ? S_P_RD : S_DONE;
                    end else if (!r_pused && !tag_rd[0]) begin
                        r_state <= S_M_ADD;
                    end else begin
                        r_state <= S_M_W1;
                    end
                end
                S_M_ADD: begin
                    r_tot   <= alu_y;
                    r_state <= S_M_W1;
                end
                S_M_W1: r_state <= S_M_W2;
                S_M_W2: begin
                    if (r_pused) begin
                        r_state <= merge_to_place ? S_P_RD : S_DONE;
                    end else begin
                        r_state <= S_M_W3;
                    end
                end
                S_M_W3: begin
                    // coalesced block starts at the previous neighbor
                    r_bp    <= alu_y;
                    r_state <= merge_to_place ? S_P_RD : S_DONE;
                end
                S_P_RD: r_state <= S_P_DEC;
                S_P_DEC: begin
                    r_size  <= tag_s;
                    r_tot   <= alu_y;
                    r_split <= (alu_y >= DS);
                    r_state <= S_P_W1;
                end
                S_P_W1: r_state <= S_P_W2;
                S_P_W2: begin
                    r_res   <= r_bp[15:0];
                    r_state <= r_split ? S_P_W3 : S_DONE;
                end
                S_P_W3: r_state <= S_P_W4;
                S_P_W4: r_state <= S_DONE;
                S_W_CHK: begin
                    r_state <= (r_bp >= r_heap_end) ? S_G_CALC : S_W_TAG;
                end
                S_W_TAG: begin
                    r_size <= tag_s;
                    if (tag_s == '0 || tag_s > alu_y) begin
                        r_state <= S_G_CALC;
                    end else if (tag_s >= r_asize && !tag_rd[0]) begin
                        r_state <= S_P_RD;
                    end else begin
                        r_state <= S_W_ADV;
                    end
                end
                S_W_ADV: begin
                    r_bp    <= alu_y;
                    r_state <= S_W_CHK;
                end
                S_G_CALC: begin
                    r_tot   <= grow_calc;
                    r_state <= S_G_CHK;
                end
                S_G_CHK: begin
                    if (alu_y > HEAP_W) begin
                        r_status <= alb_pkg::ST_OOM;
                        r_state  <= S_DONE;
                    end else begin
                        r_bp    <= r_heap_end;
                        r_size  <= r_tot;
                        r_state <= S_G_W1;
                    end
                end
                S_G_W1: r_state <= S_G_W2;
                S_G_W2: r_state <= S_G_W3;
                S_G_W3: begin
                    r_heap_end <= alu_y;
                    r_state    <= S_M_PRV;
                end
                S_DONE: begin
                    if (!r_ovld || o_rsp.ready) begin
                        r_ovld  <= 1'b1;
                        r_oaddr <= r_res;
                        r_ostat <= r_status;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
        r_roob <= !(mem_raddr < HEAP_W);
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_ovld;
    assign o_rsp.result_addr = r_oaddr;
    assign o_rsp.status      = r_ostat;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the first-fit boundary-tag heap allocator.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HEAP  = alb_pkg::HEAP_BYTES_DEF;
    localparam int unsigned CHUNK = alb_pkg::CHUNK_BYTES_DEF;
    localparam int unsigned NWORDS = HEAP / 4;
    localparam longint LIMIT_CYCLES = 40000000;

    typedef struct packed {
        logic [15:0] addr;
        logic [1:0]  status;
    } t_rsp;

    typedef struct {
        logic        kind;
        logic [16:0] size;
        logic [15:0] addr;
        logic        typed;
        t_rsp        rsp;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    alb_req_if req_ch();
    alb_rsp_if rsp_ch();

    boundary_tag_first_fit_allocator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // shadow of the heap tags
    logic [31:0] heap_tags [NWORDS];
    int unsigned heap_top;
    int unsigned first_bp;

    t_rsp        expected_rsp [$];
    int unsigned live_blocks [$];
    int          n_mismatch = 0;
    int          n_rsp = 0;
    int          n_oom = 0;
    int          n_free = 0;
    longint      cycle = 0;
    bit          hold_long = 1'b0;
    bit          rsp_flat = 1'b0;

    function automatic logic [31:0] tag_get(int unsigned a);
        return (a / 4 < NWORDS) ? heap_tags[a / 4] : 32'd0;
    endfunction

    function automatic void tag_put(int unsigned a, logic [31:0] v);
        if (a / 4 < NWORDS)
            heap_tags[a / 4] = v;
    endfunction

    function automatic int unsigned bsize(int unsigned bp);
        return tag_get(bp - 4) & ~32'h7;
    endfunction

    function automatic bit bused(int unsigned bp);
        logic [31:0] t;
        t = tag_get(bp - 4);
        return t[0];
    endfunction

    function automatic void mark(int unsigned bp, int unsigned sz, int unsigned used);
        tag_put(bp - 4, sz | used);
        tag_put(bp + sz - 8, sz | used);
    endfunction

    function automatic int unsigned coalesce(int unsigned bp);
        int unsigned sz, ptag, psz, prv, nxt;
        bit pu, nu;
        sz   = bsize(bp);
        ptag = tag_get(bp - 8);
        psz  = ptag & ~32'h7;
        prv  = bp - psz;
        nxt  = bp + sz;
        pu   = ptag[0];
        nu   = bused(nxt);
        if (pu && nu)
            return bp;
        if (pu) begin
            mark(bp, sz + bsize(nxt), 0);
            return bp;
        end
        if (nu) begin
            tag_put(prv - 4, sz + psz);
            tag_put(bp + bsize(bp) - 8, sz + psz);
            return prv;
        end
        tag_put(nxt + bsize(nxt) - 8, sz + psz + bsize(nxt));
        tag_put(prv - 4, sz + psz + bsize(nxt));
        return prv;
    endfunction

    function automatic void heap_reset();
        foreach (heap_tags[i])
            heap_tags[i] = 32'd0;
        tag_put(4, 9);
        tag_put(8, 9);
        mark(16, CHUNK, 0);
        tag_put(16 + CHUNK - 4, 1);
        heap_top = 16 + CHUNK;
        first_bp = alb_pkg::FIRST_BLOCK;
    endfunction

    function automatic t_rsp heap_step(logic kind, int unsigned rq, int unsigned a);
        t_rsp r;
        int unsigned s, asz, bp, ext, grow, rest;
        bit found;
        r = '0;
        r.status = alb_pkg::ST_DONE;
        if (kind == alb_pkg::KIND_FREE) begin
            s = bsize(a);
            if (a % 8 == 0 && a >= 16 && a < heap_top && s != 0 && s <= heap_top - a) begin
                mark(a, s, 0);
                void'(coalesce(a));
            end
        end else if (rq == 0) begin
            r.status = alb_pkg::ST_ZERO;
        end else begin
            asz = (rq <= 8) ? 16 : 8 * ((rq + 15) / 8);
            bp = first_bp;
            found = 0;
            while (bp < heap_top) begin
                s = bsize(bp);
                if (s == 0 || s > heap_top - bp)
                    break;
                if (s >= asz && !bused(bp)) begin
                    found = 1;
                    break;
                end
                bp += s;
            end
            if (!found) begin
                ext = (asz > CHUNK) ? asz : CHUNK;
                grow = ((ext / 4 + 1) / 2) * 8;
                if (heap_top + grow > HEAP) begin
                    r.status = alb_pkg::ST_OOM;
                end else begin
                    bp = heap_top;
                    mark(bp, grow, 0);
                    tag_put(bp + grow - 4, 1);
                    heap_top += grow;
                    bp = coalesce(bp);
                    found = 1;
                end
            end
            if (found) begin
                s = bsize(bp);
                rest = s - asz;
                if (rest < 8) begin
                    mark(bp, s, 1);
                end else begin
                    mark(bp, asz, 1);
                    mark(bp + asz, rest, 0);
                end
                r.addr = bp[15:0];
            end
        end
        return r;
    endfunction

    // Addresses that pass the free address check: 8-aligned, from 16 up to the heap top.
    function automatic bit tag_written(int unsigned a);
        return a >= 16 && a < heap_top && (a % 8 == 0);
    endfunction

    task automatic send_request(logic kind, int unsigned rq, int unsigned a,
                                bit typed, t_rsp want);
        t_rsp got;
        int gap;
        int hit_idx [$];
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if (rsp_flat)
            gap = 0;
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.kind       <= kind;
        req_ch.req_size   <= rq[16:0];
        req_ch.block_addr <= a[15:0];
        do @(posedge i_clk); while (!req_ch.ready);
        got = heap_step(kind, rq, a);
        if (typed && got !== want) begin
            n_mismatch++;
            if (n_mismatch <= 10)
                $display("table row mismatch: predictor %h typed %h", got, want);
        end
        expected_rsp.push_back(got);
        if (kind == alb_pkg::KIND_ALLOC && got.status == alb_pkg::ST_DONE)
            live_blocks.push_back(got.addr);
        if (kind == alb_pkg::KIND_FREE) begin
            hit_idx = live_blocks.find_first_index(x) with (x == a);
            if (hit_idx.size() != 0)
                live_blocks.delete(hit_idx[0]);
        end
        if (got.status == alb_pkg::ST_OOM)
            n_oom++;
        if (kind == alb_pkg::KIND_FREE)
            n_free++;
    endtask

    // Response side: random stalls, one long hold-off and a stretch with ready held high.
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (!i_rst_n)
            rsp_ch.ready <= 1'b0;
        else if (hold_long)
            rsp_ch.ready <= 1'b0;
        else if (rsp_flat)
            rsp_ch.ready <= 1'b1;
        else
            rsp_ch.ready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            n_rsp++;
            if (expected_rsp.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected response addr=%0d status=%0d",
                             rsp_ch.result_addr, rsp_ch.status);
            end else begin
                t_rsp w;
                w = expected_rsp.pop_front();
                if (rsp_ch.result_addr !== w.addr || rsp_ch.status !== w.status) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("response mismatch: expected addr=%0d status=%0d, got addr=%0d status=%0d",
                                 w.addr, w.status, rsp_ch.result_addr, rsp_ch.status);
                end
            end
        end
        if (cycle > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        hold_long = 1'b1;
        wait (i_rst_n);
        repeat (400) @(posedge i_clk);
        hold_long = 1'b0;
    end

    t_row table_rows [$];

    function automatic t_row row(logic k, int unsigned s, int unsigned a, bit typed,
                                 int unsigned ra, logic [1:0] st);
        t_row r;
        r.kind = k;
        r.size = s[16:0];
        r.addr = a[15:0];
        r.typed = typed;
        r.rsp.addr = ra[15:0];
        r.rsp.status = st;
        return r;
    endfunction

    initial begin
        int unsigned rq, a, k, idx;
        req_ch.valid      <= 1'b0;
        req_ch.kind       <= alb_pkg::KIND_ALLOC;
        req_ch.req_size   <= '0;
        req_ch.block_addr <= '0;
        heap_reset();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        table_rows.push_back(row(alb_pkg::KIND_ALLOC, 0, 16'hffff, 1, 0, alb_pkg::ST_ZERO));
        table_rows.push_back(row(alb_pkg::KIND_ALLOC, 1, 0, 1, 16, alb_pkg::ST_DONE));
        table_rows.push_back(row(alb_pkg::KIND_ALLOC, 8, 0, 1, 32, alb_pkg::ST_DONE));
        table_rows.push_back(row(alb_pkg::KIND_ALLOC, 9, 0, 1, 48, alb_pkg::ST_DONE));
        table_rows.push_back(row(alb_pkg::KIND_ALLOC, 65536, 0, 1, 0, alb_pkg::ST_OOM));
        table_rows.push_back(row(alb_pkg::KIND_FREE, 0, 32, 0, 0, alb_pkg::ST_DONE));
        table_rows.push_back(row(alb_pkg::KIND_FREE, 0, 32, 0, 0, alb_pkg::ST_DONE)); // double free
        table_rows.push_back(row(alb_pkg::KIND_FREE, 0, 33, 1, 0, alb_pkg::ST_DONE)); // misaligned
        table_rows.push_back(row(alb_pkg::KIND_FREE, 0, 8, 1, 0, alb_pkg::ST_DONE));  // below payload
        table_rows.push_back(row(alb_pkg::KIND_FREE, 0, 16'hfff8, 1, 0, alb_pkg::ST_DONE)); // past end
        table_rows.push_back(row(alb_pkg::KIND_ALLOC, 4000, 0, 0, 0, alb_pkg::ST_DONE));
        table_rows.push_back(row(alb_pkg::KIND_ALLOC, 5000, 0, 0, 0, alb_pkg::ST_DONE)); // grows heap
        table_rows.push_back(row(alb_pkg::KIND_FREE, 0, 16, 0, 0, alb_pkg::ST_DONE));
        table_rows.push_back(row(alb_pkg::KIND_FREE, 0, 48, 0, 0, alb_pkg::ST_DONE));
        table_rows.push_back(row(alb_pkg::KIND_ALLOC, 30000, 0, 0, 0, alb_pkg::ST_DONE));
        table_rows.push_back(row(alb_pkg::KIND_ALLOC, 40000, 0, 0, 0, alb_pkg::ST_DONE)); // no room
        table_rows.push_back(row(alb_pkg::KIND_ALLOC, 24, 0, 0, 0, alb_pkg::ST_DONE));
        foreach (table_rows[i])
            send_request(table_rows[i].kind, table_rows[i].size, table_rows[i].addr,
                         table_rows[i].typed, table_rows[i].rsp);

        for (int n = 0; n < 600; n++) begin
            rsp_flat = (n >= 250 && n < 300);
            k = $urandom_range(0, 99);
            if (k < 50) begin
                case ($urandom_range(0, 9))
                    0: rq = $urandom_range(0, 131071);
                    1: rq = $urandom_range(2000, 9000);
                    default: rq = $urandom_range(1, 300);
                endcase
                send_request(alb_pkg::KIND_ALLOC, rq, $urandom_range(0, 65535), 0, '0);
            end else if (k < 88 && live_blocks.size() > 0) begin
                idx = $urandom_range(0, live_blocks.size() - 1);
                a = live_blocks[idx];
                live_blocks.delete(idx);
                send_request(alb_pkg::KIND_FREE, $urandom_range(0, 131071), a, 0, '0);
            end else begin
                // noise free: only addresses that cannot touch unwritten tags
                a = $urandom_range(0, 65535);
                if (tag_written(a) && bsize(a) == 0 && tag_get(a - 4) == 0)
                    a = a | 1;
                if (tag_written(a))
                    a = a | 3;
                send_request(alb_pkg::KIND_FREE, $urandom_range(0, 131071), a, 0, '0);
            end
        end
        req_ch.valid <= 1'b0;

        while (expected_rsp.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("run: %0d responses, %0d frees, %0d out-of-memory, heap end %0d",
                 n_rsp, n_free, n_oom, heap_top);
        if (n_mismatch == 0 && expected_rsp.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("mismatches: %0d", n_mismatch);
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
hw/rtl/alb_pkg.sv
hw/rtl/alb_if.sv
hw/rtl/alb_alu.sv
hw/rtl/alb_tag_ram.sv
hw/rtl/boundary_tag_first_fit_allocator.sv
tb/testbench.sv
